>>> design/kpcb_pkg.sv
// shared types, constants and table functions for the keyframe pose blender
package kpcb_pkg;

	// item kinds carried in tuser
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_TARGET = 2'd1;
	localparam logic [1:0] OP_HOLD   = 2'd2;

	// register indexes, byte address is four times the index
	localparam logic [2:0] REG_TIMESTEP   = 3'd0;
	localparam logic [2:0] REG_BLEND_TIME = 3'd1;
	localparam logic [2:0] REG_BLEND_RATE = 3'd2;
	localparam logic [2:0] REG_ACT_COUNT  = 3'd3;
	localparam logic [2:0] REG_POSE_COUNT = 3'd4;

	// register reset values
	localparam logic [16:0] TIMESTEP_RST   = 17'd131;
	localparam logic [31:0] BLEND_TIME_RST = 32'd65536;
	localparam logic [24:0] BLEND_RATE_RST = 25'd65536;
	localparam logic [5:0]  ACT_COUNT_RST  = 6'd30;
	localparam logic [4:0]  POSE_COUNT_RST = 5'd0;

	// shared multiplier operand widths
	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 26;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// fixed point constants for the cosine table
	localparam logic [63:0]        PI_Q30     = 64'd3373259426;
	localparam logic [63:0]        ONE_Q30    = 64'd1073741824;
	localparam logic signed [63:0] ONE_Q30_S  = 64'sd1073741824;

	typedef struct packed {
		logic [16:0] timestep;
		logic [31:0] blend_time;
		logic [24:0] blend_rate;
		logic [5:0]  actuator_count;
		logic [4:0]  pose_count;
	} cfg_t;

	typedef struct packed {
		logic tgt;
		logic hold;
		logic prev;
	} mem_we_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ELAP,
		S_CMP,
		S_SNAP,
		S_MOD,
		S_PH_LO,
		S_PH_HI,
		S_PH_SUM,
		S_ALPHA,
		S_B_MUL,
		S_B_OUT
	} state_t;

	// blend weight for the rising half of the cosine, q1.15
	function automatic logic [15:0] alpha_low_half(input logic [63:0] k, input int bits);
		logic [63:0]        u;
		logic [63:0]        u2;
		logic [63:0]        t;
		logic signed [63:0] c;
		logic signed [63:0] d;
		u  = (PI_Q30 * k) >> bits;
		u2 = (u * u) >> 30;
		t  = ONE_Q30;
		c  = ONE_Q30_S;
		t  = ((t * u2) >> 30) / 64'd2;
		c  = c - $signed(t);
		t  = ((t * u2) >> 30) / 64'd12;
		c  = c + $signed(t);
		t  = ((t * u2) >> 30) / 64'd30;
		c  = c - $signed(t);
		t  = ((t * u2) >> 30) / 64'd56;
		c  = c + $signed(t);
		t  = ((t * u2) >> 30) / 64'd90;
		c  = c - $signed(t);
		t  = ((t * u2) >> 30) / 64'd132;
		c  = c + $signed(t);
		if (c > ONE_Q30_S) begin
			c = ONE_Q30_S;
		end
		d = ONE_Q30_S - c;
		return 16'(64'(d + 64'sd32768) >> 16);
	endfunction

	// full table entry, mirrored about the midpoint
	function automatic logic [15:0] alpha_entry(input logic [63:0] k, input int bits);
		logic [63:0] full;
		logic [63:0] kc;
		full = 64'd1 << bits;
		kc   = (k > full) ? full : k;
		if (kc <= (full >> 1)) begin
			return alpha_low_half(kc, bits);
		end
		return 16'(17'd32768 - 17'(alpha_low_half(full - kc, bits)));
	endfunction

endpackage

>>> design/kpcb_cfg.sv
// configuration register file behind the apb-style port
module kpcb_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output kpcb_pkg::cfg_t     cfg
);

	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign idx    = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.timestep       <= kpcb_pkg::TIMESTEP_RST;
			cfg.blend_time     <= kpcb_pkg::BLEND_TIME_RST;
			cfg.blend_rate     <= kpcb_pkg::BLEND_RATE_RST;
			cfg.actuator_count <= kpcb_pkg::ACT_COUNT_RST;
			cfg.pose_count     <= kpcb_pkg::POSE_COUNT_RST;
		end else if (wr) begin
			unique case (idx)
				kpcb_pkg::REG_TIMESTEP:   cfg.timestep       <= pwdata[16:0];
				kpcb_pkg::REG_BLEND_TIME: cfg.blend_time     <= pwdata;
				kpcb_pkg::REG_BLEND_RATE: cfg.blend_rate     <= pwdata[24:0];
				kpcb_pkg::REG_ACT_COUNT:  cfg.actuator_count <= pwdata[5:0];
				kpcb_pkg::REG_POSE_COUNT: cfg.pose_count     <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			kpcb_pkg::REG_TIMESTEP:   prdata = {15'd0, cfg.timestep};
			kpcb_pkg::REG_BLEND_TIME: prdata = cfg.blend_time;
			kpcb_pkg::REG_BLEND_RATE: prdata = {7'd0, cfg.blend_rate};
			kpcb_pkg::REG_ACT_COUNT:  prdata = {26'd0, cfg.actuator_count};
			kpcb_pkg::REG_POSE_COUNT: prdata = {27'd0, cfg.pose_count};
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

>>> design/kpcb_mul.sv
// shared signed multiplier with registered product
module kpcb_mul (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [kpcb_pkg::MUL_A_W-1:0]   a,
	input  logic signed [kpcb_pkg::MUL_B_W-1:0]   b,
	output logic signed [kpcb_pkg::MUL_P_W-1:0]   p_s1
);

	// product register holds while not enabled
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= a * b;
		end
	end

endmodule

>>> design/kpcb_alpha_rom.sv
// raised-cosine blend weight table, q1.15, registered read
module kpcb_alpha_rom #(
	parameter int TABLE_BITS = 10
) (
	input  logic                clk,
	input  logic [TABLE_BITS:0] k,
	output logic [15:0]         alpha_q
);

	localparam int RomDepth = (1 << TABLE_BITS) + 1;

	logic [15:0] rom [RomDepth];

	// table contents fixed at elaboration
	for (genvar g = 0; g < RomDepth; g++) begin : g_rom
		assign rom[g] = kpcb_pkg::alpha_entry(64'(g), TABLE_BITS);
	end

	always_ff @(posedge clk) begin
		alpha_q <= rom[k];
	end

endmodule

>>> design/kpcb_store.sv
// target, hold and previous-value memories
module kpcb_store #(
	parameter int MAX_ACTUATORS = 32,
	parameter int MAX_POSES     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kpcb_pkg::mem_we_t     we,
	input  logic [TAW-1:0]        tgt_waddr,
	input  logic [15:0]           tgt_wdata,
	input  logic [TAW-1:0]        tgt_raddr,
	output logic [15:0]           tgt_rdata_q,
	input  logic [PW-1:0]         hold_waddr,
	input  logic [31:0]           hold_wdata,
	input  logic [PW-1:0]         hold_raddr,
	output logic [31:0]           hold_rdata_q,
	input  logic [AW-1:0]         prev_waddr,
	input  logic [15:0]           prev_wdata,
	input  logic [AW-1:0]         prev_raddr,
	output logic [15:0]           prev_rdata
);

	localparam int AW  = (MAX_ACTUATORS > 1) ? $clog2(MAX_ACTUATORS) : 1;
	localparam int PW  = (MAX_POSES > 1) ? $clog2(MAX_POSES) : 1;
	localparam int TAW = (MAX_POSES * MAX_ACTUATORS > 1) ?
		$clog2(MAX_POSES * MAX_ACTUATORS) : 1;

	logic [15:0]              tgt_mem  [MAX_POSES * MAX_ACTUATORS];
	logic [31:0]              hold_mem [MAX_POSES];
	logic [15:0]              prev_mem [MAX_ACTUATORS];
	logic [MAX_ACTUATORS-1:0] prev_valid_q;
	logic [15:0]              prev_mem_q;
	logic                     prev_vld_q;

	// target angles per pose and actuator
	always_ff @(posedge clk) begin
		if (we.tgt) begin
			tgt_mem[tgt_waddr] <= tgt_wdata;
		end
		tgt_rdata_q <= tgt_mem[tgt_raddr];
	end

	// hold time per pose
	always_ff @(posedge clk) begin
		if (we.hold) begin
			hold_mem[hold_waddr] <= hold_wdata;
		end
		hold_rdata_q <= hold_mem[hold_raddr];
	end

	// previous values, zero until first snapshot
	always_ff @(posedge clk) begin
		if (we.prev) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		prev_mem_q <= prev_mem[prev_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= '0;
			prev_vld_q   <= 1'b0;
		end else begin
			if (we.prev) begin
				prev_valid_q[prev_waddr] <= 1'b1;
			end
			prev_vld_q <= prev_valid_q[prev_raddr];
		end
	end

	assign prev_rdata = prev_vld_q ? prev_mem_q : 16'd0;

endmodule

>>> design/keyframe_pose_cosine_blender.sv
// keyframe pose player: sequencer, output register and unit hookup
//
// Input stream s_*: s_tuser carries the item kind (tick, target write, hold
// write); s_tdata carries pose, actuator, angle and hold time. Write items are
// taken without leaving the idle state and give no results. A tick, when the
// pose count is not zero, advances the elapsed time, moves to the next pose
// once blend plus hold time has run out, and then emits one result per
// actuator on m_*, m_tlast marking the last of the tick. Configuration goes
// through the apb-style port; the user must write it only while idle, and the
// block itself does not enforce this. A tick is paced by the single shared
// multiplier (two passes for the phase product, one per actuator for the blend)
// and by the single read port of the target memory; a pose change adds a
// snapshot of the old pose and wrap steps of the pose pointer. s_tready is low
// while a tick is being worked. Reset sets the registers to their defaults,
// clears the previous values, pose pointer and elapsed time; target and hold
// tables hold nothing defined until written. A stalled receiver keeps the
// result in the output register and pauses the actuator walk; a finished tick
// frees the input side even while its last result is still waiting.
module keyframe_pose_cosine_blender #(
	parameter int MAX_ACTUATORS  = 32,
	parameter int MAX_POSES      = 16,
	parameter int COS_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pose_number, actuator_number, angle, hold_time
	input  logic [1:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // actuator_out, drive_value, active_pose
	output logic        m_tlast,   // last_of_tick
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW   = (MAX_ACTUATORS > 1) ? $clog2(MAX_ACTUATORS) : 1;
	localparam int PW   = (MAX_POSES > 1) ? $clog2(MAX_POSES) : 1;
	localparam int TAW  = (MAX_POSES * MAX_ACTUATORS > 1) ?
		$clog2(MAX_POSES * MAX_ACTUATORS) : 1;
	localparam int RW   = PW + 1;
	localparam int MW   = (RW > 5) ? RW : 5;
	localparam int NCAP = (MAX_ACTUATORS < 32) ? MAX_ACTUATORS : 32;
	localparam int KW   = COS_TABLE_BITS + 1;

	kpcb_pkg::cfg_t    cfg;
	kpcb_pkg::state_t  state_q, state_d;
	kpcb_pkg::mem_we_t we;

	// input fields
	logic [1:0]  in_op;
	logic [3:0]  in_pose;
	logic [4:0]  in_act;
	logic [15:0] in_angle;
	logic [31:0] in_hold;
	logic        in_acc;
	logic        tick_go;

	// derived counts
	logic [4:0]  poses;
	logic [5:0]  nact;
	logic        i_last;

	// control state
	logic [AW-1:0] i_q;
	logic [AW-1:0] rd_idx;
	logic [PW-1:0] ptr_q;
	logic [33:0]   elapsed_q;
	logic [RW-1:0] rem_q;
	logic          snap_we_s1;
	logic [AW-1:0] snap_idx_s1;

	// memory ports
	logic [TAW-1:0] tgt_waddr;
	logic [TAW-1:0] tgt_raddr;
	logic [15:0]    tgt_rdata;
	logic [PW-1:0]  hold_waddr;
	logic [31:0]    hold_rdata;
	logic [15:0]    prev_rdata;

	// arithmetic
	logic signed [kpcb_pkg::MUL_A_W-1:0] mul_a;
	logic signed [kpcb_pkg::MUL_B_W-1:0] mul_b;
	logic signed [kpcb_pkg::MUL_P_W-1:0] mul_p;
	logic                                mul_en;
	logic [41:0]                         acc_q;
	logic [KW-1:0]                       k_q;
	logic [15:0]                         alpha;
	logic signed [15:0]                  prev_s1;
	logic [34:0]                         elap_sum;
	logic [32:0]                         total;
	logic                                advance;
	logic                                rem_ge;
	logic [58:0]                         phase_sum;
	logic [42:0]                         phase_hi;
	logic [16:0]                         phase_c;
	logic signed [16:0]                  diff;
	logic signed [32:0]                  rnd;
	logic signed [17:0]                  q18;
	logic signed [17:0]                  v18;

	// output register
	logic        out_free;
	logic        out_load;
	logic        out_vld_q;
	logic [4:0]  out_act_q;
	logic [15:0] out_drive_q;
	logic [3:0]  out_pose_q;
	logic        out_last_q;

	kpcb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input decode
	assign in_op    = s_tuser;
	assign in_pose  = s_tdata[3:0];
	assign in_act   = s_tdata[8:4];
	assign in_angle = s_tdata[24:9];
	assign in_hold  = s_tdata[56:25];
	assign s_tready = (state_q == kpcb_pkg::S_IDLE);
	assign in_acc   = s_tvalid & s_tready;

	assign poses = (32'(cfg.pose_count) > MAX_POSES) ? 5'(MAX_POSES) : cfg.pose_count;
	assign nact  = (32'(cfg.actuator_count) > NCAP) ? 6'(NCAP) : cfg.actuator_count;
	assign i_last = (6'(i_q) == (nact - 6'd1));
	assign tick_go = in_acc && (in_op == kpcb_pkg::OP_TICK) && (poses != 5'd0);

	// table writes straight from the accepted request
	assign we.tgt = in_acc && (in_op == kpcb_pkg::OP_TARGET) &&
		(32'(in_pose) < MAX_POSES) && (32'(in_act) < MAX_ACTUATORS);
	assign we.hold = in_acc && (in_op == kpcb_pkg::OP_HOLD) && (32'(in_pose) < MAX_POSES);
	assign we.prev = snap_we_s1;
	assign tgt_waddr  = TAW'(32'(in_pose) * MAX_ACTUATORS + 32'(in_act));
	assign hold_waddr = PW'(in_pose);

	// read address runs one ahead while a result is being handed over
	assign rd_idx    = (state_q == kpcb_pkg::S_B_OUT) ? i_q + AW'(1) : i_q;
	assign tgt_raddr = TAW'(32'(ptr_q) * MAX_ACTUATORS + 32'(rd_idx));

	kpcb_store #(
		.MAX_ACTUATORS (MAX_ACTUATORS),
		.MAX_POSES     (MAX_POSES)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.we           (we),
		.tgt_waddr    (tgt_waddr),
		.tgt_wdata    (in_angle),
		.tgt_raddr    (tgt_raddr),
		.tgt_rdata_q  (tgt_rdata),
		.hold_waddr   (hold_waddr),
		.hold_wdata   (in_hold),
		.hold_raddr   (ptr_q),
		.hold_rdata_q (hold_rdata),
		.prev_waddr   (snap_idx_s1),
		.prev_wdata   (tgt_rdata),
		.prev_raddr   (rd_idx),
		.prev_rdata   (prev_rdata)
	);

	kpcb_alpha_rom #(
		.TABLE_BITS (COS_TABLE_BITS)
	) u_rom (
		.clk     (clk),
		.k       (k_q),
		.alpha_q (alpha)
	);

	// multiplier operand select
	assign diff = $signed({tgt_rdata[15], tgt_rdata}) - $signed({prev_rdata[15], prev_rdata});
	always_comb begin
		mul_a = $signed({1'b0, elapsed_q[16:0]});
		mul_b = $signed({1'b0, cfg.blend_rate});
		unique case (state_q)
			kpcb_pkg::S_PH_HI: mul_a = $signed({1'b0, elapsed_q[33:17]});
			kpcb_pkg::S_B_MUL: begin
				mul_a = $signed({diff[16], diff});
				mul_b = $signed({10'd0, alpha});
			end
			default: ;
		endcase
	end
	assign mul_en = (state_q == kpcb_pkg::S_PH_LO) || (state_q == kpcb_pkg::S_PH_HI) ||
		(state_q == kpcb_pkg::S_B_MUL);

	kpcb_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	// elapsed time and pose switch test
	assign elap_sum = {1'b0, elapsed_q} + 35'(cfg.timestep);
	assign total    = {1'b0, cfg.blend_time} + {1'b0, hold_rdata};
	assign advance  = ({1'b0, elapsed_q} >= {2'b00, total});
	assign rem_ge   = (MW'(rem_q) >= MW'(poses));

	// phase from the two partial products, clamped to one
	assign phase_sum = {mul_p[41:0], 17'd0} + 59'(acc_q);
	assign phase_hi  = phase_sum[58:16];
	assign phase_c   = (phase_hi > 43'd65536) ? 17'd65536 : phase_hi[16:0];

	// rounded blend of the registered product
	assign rnd = $signed(mul_p[32:0]) + 33'sd16384;
	assign q18 = 18'(rnd >>> 15);
	assign v18 = $signed({{2{prev_s1[15]}}, prev_s1}) + q18;

	assign out_free = !out_vld_q || m_tready;

	// next state
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			kpcb_pkg::S_IDLE: begin
				if (tick_go) state_d = kpcb_pkg::S_ELAP;
			end
			kpcb_pkg::S_ELAP: state_d = kpcb_pkg::S_CMP;
			kpcb_pkg::S_CMP: begin
				if (!advance) state_d = kpcb_pkg::S_PH_LO;
				else if (nact == 6'd0) state_d = kpcb_pkg::S_MOD;
				else state_d = kpcb_pkg::S_SNAP;
			end
			kpcb_pkg::S_SNAP: begin
				if (i_last) state_d = kpcb_pkg::S_MOD;
			end
			kpcb_pkg::S_MOD: begin
				if (!rem_ge) state_d = kpcb_pkg::S_PH_LO;
			end
			kpcb_pkg::S_PH_LO:  state_d = kpcb_pkg::S_PH_HI;
			kpcb_pkg::S_PH_HI:  state_d = kpcb_pkg::S_PH_SUM;
			kpcb_pkg::S_PH_SUM: begin
				state_d = (nact == 6'd0) ? kpcb_pkg::S_IDLE : kpcb_pkg::S_ALPHA;
			end
			kpcb_pkg::S_ALPHA: state_d = kpcb_pkg::S_B_MUL;
			kpcb_pkg::S_B_MUL: state_d = kpcb_pkg::S_B_OUT;
			kpcb_pkg::S_B_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = i_last ? kpcb_pkg::S_IDLE : kpcb_pkg::S_B_MUL;
				end
			end
			default: state_d = kpcb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpcb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer counters, pose pointer and elapsed time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			ptr_q      <= '0;
			elapsed_q  <= '0;
			rem_q      <= '0;
			snap_we_s1 <= 1'b0;
		end else begin
			snap_we_s1 <= (state_q == kpcb_pkg::S_SNAP);
			unique case (state_q)
				kpcb_pkg::S_ELAP: begin
					elapsed_q <= elap_sum[34] ? '1 : elap_sum[33:0];
				end
				kpcb_pkg::S_CMP: begin
					i_q <= '0;
					if (advance) begin
						elapsed_q <= '0;
						rem_q     <= RW'(ptr_q) + RW'(1);
					end
				end
				kpcb_pkg::S_SNAP: i_q <= i_q + AW'(1);
				kpcb_pkg::S_MOD: begin
					if (rem_ge) rem_q <= RW'(MW'(rem_q) - MW'(poses));
					else ptr_q <= PW'(rem_q);
				end
				kpcb_pkg::S_PH_SUM: i_q <= '0;
				kpcb_pkg::S_B_OUT: begin
					if (out_load) i_q <= i_q + AW'(1);
				end
				default: ;
			endcase
		end
	end

	// datapath holding registers
	always_ff @(posedge clk) begin
		snap_idx_s1 <= i_q;
		if (state_q == kpcb_pkg::S_PH_HI) acc_q <= mul_p[41:0];
		if (state_q == kpcb_pkg::S_PH_SUM) k_q <= phase_c[16 -: KW];
		if (state_q == kpcb_pkg::S_B_MUL) prev_s1 <= $signed(prev_rdata);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_act_q   <= 5'(i_q);
			out_drive_q <= v18[15:0];
			out_pose_q  <= 4'(ptr_q);
			out_last_q  <= i_last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_pose_q, out_drive_q, out_act_q};
	assign m_tlast  = out_last_q;

endmodule

>>> design/kpcb_checker.sv
// port-level checks for the keyframe pose blender, bound to the top level
module kpcb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// idle block stays ready until a request arrives
	a_idle_stays: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |=> s_tready)
		else $error("ready dropped without a request");

	// table writes leave the input side ready for the next request
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != kpcb_pkg::OP_TICK) |=> s_tready)
		else $error("write request held the input side");

	// padding above the result fields stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:25] == 7'd0))
		else $error("result padding not zero");

endmodule

bind keyframe_pose_cosine_blender kpcb_checker u_kpcb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
